FILE: rtl/tpd_pkg.sv
// Package for the triac phase dimmer.
// Holds the command codes, field widths and the update bundle for the pattern bank.
// No dependencies.
package tpd_pkg;

	localparam int CMD_W   = 3;
	localparam int MASK_W  = 8;
	localparam int LEVEL_W = 4;
	localparam int PHASE_W = 3;
	localparam int DRIVE_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_ENABLE  = 3'd1,
		CMD_DISABLE = 3'd2,
		CMD_ALLOC   = 3'd3,
		CMD_FREE    = 3'd4,
		CMD_ON      = 3'd5,
		CMD_OFF     = 3'd6,
		CMD_BRIGHT  = 3'd7
	} cmd_t;

	typedef struct packed {
		logic               en;
		cmd_t               cmd;
		logic [MASK_W-1:0]  mask;
		logic [LEVEL_W-1:0] level;
	} upd_t;

endpackage

FILE: rtl/tpd_pattern_bank.sv
// Per-phase drive pattern rows of the triac phase dimmer.
// Applies allocate, effect on/off and brightness updates to all rows at once.
// Depends on tpd_pkg.
module tpd_pattern_bank #(
	parameter int LEVELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tpd_pkg::upd_t                upd,
	input  logic [tpd_pkg::PHASE_W-1:0]  phase,
	output logic [tpd_pkg::DRIVE_W-1:0]  row
);
	import tpd_pkg::*;

	localparam int CW = $clog2(2 * LEVELS + 16);
	localparam logic [CW-1:0] LEVELS_C = CW'(LEVELS);

	logic [MASK_W-1:0] rows_q [LEVELS];
	logic [MASK_W-1:0] rows_d [LEVELS];
	logic [CW-1:0]     bright;
	logic [CW-1:0]     phase_x;

	always_comb begin
		bright = CW'(upd.level);
		if (bright > LEVELS_C) begin
			bright = '0;
		end
		for (int i = 0; i < LEVELS; i++) begin
			rows_d[i] = rows_q[i];
			if (upd.en) begin
				case (upd.cmd) inside
					CMD_ALLOC, CMD_OFF: rows_d[i] = rows_q[i] & ~upd.mask;
					CMD_ON: rows_d[i] = rows_q[i] | upd.mask;
					CMD_BRIGHT: begin
						if (CW'(i) + bright >= LEVELS_C) begin
							rows_d[i] = rows_q[i] | upd.mask;
						end else begin
							rows_d[i] = rows_q[i] & ~upd.mask;
						end
					end
					default: rows_d[i] = rows_q[i];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				rows_q[i] <= rows_d[i];
			end
		end
	end

	always_comb begin
		phase_x = CW'(phase);
		row = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (phase_x == CW'(i)) begin
				row = row | rows_q[i];
			end
		end
	end

endmodule

FILE: rtl/triac_phase_dimmer.sv
// Top level of the triac phase dimmer for eight AC lamp-string outputs.
// Depends on tpd_pkg and tpd_pattern_bank.

// One beat is accepted every cycle unless a tick waits on a stalled output. A beat first
// lands in an input register; from there a command updates the enable, allocation and
// pattern state in the next cycle, and a tick computes its drive word into the output
// register when the output is free. Throughput is set by that single input register:
// a tick held there by a stalled output blocks the input until the output is taken.
// Commands other than tick produce no output beat.
module triac_phase_dimmer #(
	parameter int LEVELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tpd_pkg::CMD_W-1:0]    cmd,
	input  logic [tpd_pkg::MASK_W-1:0]   mask,
	input  logic [tpd_pkg::LEVEL_W-1:0]  level,
	input  logic [tpd_pkg::PHASE_W-1:0]  phase,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tpd_pkg::DRIVE_W-1:0]  drive
);
	import tpd_pkg::*;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic [MASK_W-1:0]  mask_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [PHASE_W-1:0] phase_s1;

	logic [MASK_W-1:0]  base_q;
	logic [MASK_W-1:0]  owned_q;
	logic [DRIVE_W-1:0] drive_q;
	logic               out_valid_q;

	logic               is_tick;
	logic               adv;
	upd_t               upd;
	logic [DRIVE_W-1:0] row;

	assign is_tick  = (cmd_s1 == CMD_TICK);
	assign adv      = valid_s1 && (!is_tick || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	assign upd.en    = adv && !is_tick;
	assign upd.cmd   = cmd_s1;
	assign upd.mask  = mask_s1;
	assign upd.level = level_s1;

	tpd_pattern_bank #(
		.LEVELS(LEVELS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.phase  (phase_s1),
		.row    (row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= cmd_t'(cmd);
			mask_s1  <= mask;
			level_s1 <= level;
			phase_s1 <= phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			owned_q <= '0;
		end else if (upd.en) begin
			case (cmd_s1)
				CMD_ENABLE: base_q <= base_q | mask_s1;
				CMD_DISABLE: base_q <= base_q & ~mask_s1;
				CMD_ALLOC: owned_q <= owned_q | mask_s1;
				CMD_FREE: owned_q <= owned_q & ~mask_s1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_tick) begin
			drive_q <= (base_q & ~owned_q) | row;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	a_tick_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_tick && !adv) |-> (out_valid && !out_ready))
		else $error("tick held in input register without a stalled output");

	a_tick_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_tick) |=> (out_valid && drive == $past((base_q & ~owned_q) | row)))
		else $error("tick did not produce its drive beat");

	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.en && cmd_s1 == CMD_ALLOC) |=> ((owned_q & $past(mask_s1)) == $past(mask_s1)))
		else $error("allocate did not take ownership of masked outputs");

endmodule
